// ===== rtl/bhs_pkg.sv =====
// Shared types and constants for the bitset hash set.
`default_nettype none

package bhs_pkg;

   localparam int MODULUS_DEF   = 251;
   localparam int SLOTS_DEF     = 8;
   localparam int KEY_WORDS_DEF = 5;

   localparam int WORD_W     = 64;
   localparam int IN_WORDS   = 5;
   localparam int STATUS_W   = 2;
   localparam int HASH_OUT_W = 8;
   localparam int SLOT_OUT_W = 3;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FOUND    = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      H_IDLE,
      H_LOAD,
      H_REDW,
      H_MULT,
      H_REDP,
      H_DONE
   } hash_state_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_CHECK,
      S_RESP
   } ctl_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/bitset_hash_set_insert_or_find.sv =====
// Top level of the bitset hash set: request control, bucket scan and response.
`default_nettype none

// A request is taken when start is high and busy is low; the block stays busy until
// its single result appears on the rsp_ ports with rsp_valid high for exactly one cycle,
// and the receiver cannot stall it. With the default sizes a request goes through the
// hash (per key word: one load, eight 8-bit steps, one multiply and one reduction of
// the product, all through one shared modular reduction unit, then a hand-over of the
// bucket) and then through a read and a check per bucket slot scanned in the slot
// memory, whose read and write ports share one address. The next request can be taken
// in the cycle after the result. After reset the block clears the slot memory, one row
// per cycle, and stays busy until all HASH_MODULUS * SLOTS_PER_BUCKET rows (2008 with
// the defaults) are cleared.
module bitset_hash_set_insert_or_find import bhs_pkg::*; #(
   parameter int HASH_MODULUS     = MODULUS_DEF,
   parameter int SLOTS_PER_BUCKET = SLOTS_DEF,
   parameter int KEY_WORDS        = KEY_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [WORD_W-1:0]     req_key_word0,
   input  logic [WORD_W-1:0]     req_key_word1,
   input  logic [WORD_W-1:0]     req_key_word2,
   input  logic [WORD_W-1:0]     req_key_word3,
   input  logic [WORD_W-1:0]     req_key_word4,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [HASH_OUT_W-1:0] rsp_bucket_hash,
   output logic [SLOT_OUT_W-1:0] rsp_slot_index
);

   localparam int HASH_W = $clog2(HASH_MODULUS);
   localparam int DEPTH  = HASH_MODULUS * SLOTS_PER_BUCKET;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int KEY_W  = KEY_WORDS * WORD_W;

   ctl_state_type state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             zero_key_ff, zero_key_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [SW-1:0]    slot_ff, slot_in;
   status_type       status_ff, status_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic [WORD_W-1:0] req_words [IN_WORDS];
   logic [KEY_W-1:0]  key_req;
   logic              accept;
   logic              hash_start;
   logic              hash_done;
   logic [HASH_W-1:0] hash;
   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     mem_addr;
   logic [KEY_W-1:0]  mem_wdata;
   logic [KEY_W-1:0]  mem_rdata;
   logic              slot_empty;
   logic              slot_match;
   logic              last_slot;
   status_type        scan_status;

   assign req_words[0] = req_key_word0;
   assign req_words[1] = req_key_word1;
   assign req_words[2] = req_key_word2;
   assign req_words[3] = req_key_word3;
   assign req_words[4] = req_key_word4;

   for (genvar w = 0; w < KEY_WORDS; w++) begin : g_key
      if (w < IN_WORDS) begin : g_port
         assign key_req[w*WORD_W +: WORD_W] = req_words[w];
      end else begin : g_zero
         assign key_req[w*WORD_W +: WORD_W] = '0;
      end
   end

   assign accept     = start && !busy;
   assign slot_empty = (mem_rdata == '0);
   assign slot_match = (mem_rdata == key_ff);
   assign last_slot  = (slot_ff == SW'(SLOTS_PER_BUCKET - 1));
   assign mem_addr   = (state_ff == S_CLEAR) ? clr_ff : AW'(base_ff + AW'(slot_ff));
   assign mem_wdata  = (state_ff == S_CLEAR) ? '0 : key_ff;

   bhs_hash #(
      .HASH_MODULUS (HASH_MODULUS),
      .KEY_WORDS    (KEY_WORDS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_ff),
      .done  (hash_done),
      .hash  (hash)
   );

   bhs_slot_mem #(
      .DEPTH (DEPTH),
      .WIDTH (KEY_W)
   ) u_slot_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (slot_empty || slot_match || last_slot) begin
               state_in = S_RESP;
            end else begin
               state_in = S_READ;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy          = (state_ff != S_IDLE);
      rsp_valid     = (state_ff == S_RESP);
      hash_start    = (state_ff == S_IDLE) && start;
      mem_ctl.wr_en = (state_ff == S_CLEAR) || ((state_ff == S_CHECK) && slot_empty);
      mem_ctl.rd_en = (state_ff == S_READ);
   end

   always_comb begin
      if (slot_empty) begin
         scan_status = ST_INSERTED;
      end else if (slot_match) begin
         scan_status = ST_FOUND;
      end else begin
         scan_status = ST_FULL;
      end
   end

   always_comb begin
      key_in      = key_ff;
      zero_key_in = zero_key_ff;
      base_in     = base_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      clr_in      = clr_ff;
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + AW'(1);
         S_IDLE: begin
            if (accept) begin
               key_in      = key_req;
               zero_key_in = (key_req == '0);
            end
         end
         S_HASH: begin
            base_in = AW'(AW'(hash) * AW'(SLOTS_PER_BUCKET));
            slot_in = '0;
         end
         S_CHECK: begin
            if (slot_empty || slot_match || last_slot) begin
               // An all-zero key looks like an empty slot and always reports inserted.
               status_in = zero_key_ff ? ST_INSERTED : scan_status;
               if (!slot_empty && !slot_match) begin
                  slot_in = '0;
               end
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      zero_key_ff <= zero_key_in;
      base_ff     <= base_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
   end

   assign rsp_status      = STATUS_W'(status_ff);
   assign rsp_bucket_hash = HASH_OUT_W'(hash);
   assign rsp_slot_index  = SLOT_OUT_W'(slot_ff);

`ifndef SYNTH
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after taking a request");

   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STATUS_W'(ST_FULL)) || (rsp_slot_index == '0))
      else $error("full bucket reported with a nonzero slot");

   a_write_empty_only: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CHECK) && mem_ctl.wr_en) |-> (mem_rdata == '0))
      else $error("key written over an occupied slot");

   a_no_hash_while_busy: assert property (@(posedge clock) disable iff (reset)
      hash_start |-> (state_ff == S_IDLE) && !$past(hash_start))
      else $error("hash started while a request was in progress");
`endif

endmodule

`default_nettype wire

// ===== rtl/bhs_hash.sv =====
// Iterative bucket hash: one shared modular reduction unit under a small sequencer.
`default_nettype none

module bhs_hash import bhs_pkg::*; #(
   parameter int HASH_MODULUS = MODULUS_DEF,
   parameter int KEY_WORDS    = KEY_WORDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [KEY_WORDS*WORD_W-1:0]         key,
   output logic                                done,
   output logic [$clog2(HASH_MODULUS)-1:0]     hash
);

   localparam int HASH_W = $clog2(HASH_MODULUS);
   localparam int RED_W  = 2 * HASH_W;
   localparam int MU_W   = HASH_W + 1;
   localparam int QP_W   = RED_W + MU_W;
   localparam int DIFF_W = RED_W + 1;
   localparam int REM_W  = HASH_W + 2;
   localparam int CHUNKS = (WORD_W + HASH_W - 1) / HASH_W;
   localparam int OPER_W = CHUNKS * HASH_W;
   localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int WI_W   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam logic [MU_W-1:0]   MU    =
      MU_W'((longint'(1) << RED_W) / longint'(HASH_MODULUS));
   localparam logic [DIFF_W-1:0] MOD_D = DIFF_W'(HASH_MODULUS);
   localparam logic [REM_W-1:0]  MOD_R = REM_W'(HASH_MODULUS);

   hash_state_type state_ff, state_in;
   logic [WI_W-1:0]   word_ff, word_in;
   logic [OPER_W-1:0] oper_ff, oper_in;
   logic [HASH_W-1:0] rem_ff, rem_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              phase_ff, phase_in;
   logic [MU_W-1:0]   quot_ff, quot_in;

   logic [RED_W-1:0]  red_val;
   logic [QP_W-1:0]   quot_prod;
   logic [DIFF_W-1:0] diff;
   logic [REM_W-1:0]  rem_a;
   logic [REM_W-1:0]  rem_b;
   logic [REM_W-1:0]  rem_c;
   logic [HASH_W-1:0] red_out;
   logic [RED_W-1:0]  prod;
   logic              last_word;
   logic              last_chunk;

   // Shared unit: Barrett reduction of {rem_ff, top chunk of oper_ff}. It first registers the
   // quotient estimate in quot_ff, then subtracts it and corrects the remainder.
   assign red_val   = {rem_ff, oper_ff[OPER_W-1 -: HASH_W]};
   assign quot_prod = QP_W'(red_val) * QP_W'(MU);
   assign quot_in   = quot_prod[RED_W +: MU_W];
   assign diff      = DIFF_W'(red_val) - DIFF_W'(DIFF_W'(quot_ff) * MOD_D);
   assign rem_a     = REM_W'(diff);
   assign rem_b     = (rem_a >= MOD_R) ? REM_W'(rem_a - MOD_R) : rem_a;
   assign rem_c     = (rem_b >= MOD_R) ? REM_W'(rem_b - MOD_R) : rem_b;
   assign red_out   = HASH_W'(rem_c);

   assign prod = RED_W'(RED_W'(h_ff) * RED_W'(rem_ff) + RED_W'(h_ff));
   assign last_word  = (word_ff == WI_W'(KEY_WORDS - 1));
   assign last_chunk = (cnt_ff == CNT_W'(CHUNKS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               state_in = H_LOAD;
            end
         end
         H_LOAD: state_in = H_REDW;
         H_REDW: begin
            if (phase_ff && last_chunk) begin
               state_in = H_MULT;
            end
         end
         H_MULT: state_in = H_REDP;
         H_REDP: begin
            if (phase_ff) begin
               state_in = last_word ? H_DONE : H_LOAD;
            end
         end
         H_DONE: state_in = H_IDLE;
         default: state_in = H_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == H_DONE);
      hash = h_ff;
   end

   always_comb begin
      word_in  = word_ff;
      oper_in  = oper_ff;
      rem_in   = rem_ff;
      h_in     = h_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               h_in    = HASH_W'(1);
               word_in = '0;
            end
         end
         H_LOAD: begin
            oper_in  = OPER_W'(key[int'(word_ff) * WORD_W +: WORD_W]);
            rem_in   = '0;
            cnt_in   = '0;
            phase_in = 1'b0;
         end
         H_REDW: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               rem_in  = red_out;
               oper_in = oper_ff << HASH_W;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         H_MULT: begin
            rem_in   = prod[RED_W-1 -: HASH_W];
            oper_in  = {prod[HASH_W-1:0], {(OPER_W - HASH_W){1'b0}}};
            phase_in = 1'b0;
         end
         H_REDP: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               h_in    = red_out;
               word_in = word_ff + WI_W'(1);
            end
         end
         default: begin
            h_in = h_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      oper_ff  <= oper_in;
      rem_ff   <= rem_in;
      h_ff     <= h_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      quot_ff  <= quot_in;
   end

endmodule

`default_nettype wire

// ===== rtl/bhs_slot_mem.sv =====
// Slot memory holding one stored key per row, with a registered read port.
`default_nettype none

module bhs_slot_mem import bhs_pkg::*; #(
   parameter int DEPTH = MODULUS_DEF * SLOTS_DEF,
   parameter int WIDTH = KEY_WORDS_DEF * WORD_W
) (
   input  logic                     clock,
   input  mem_ctl_type              ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
